[rtl/core/eptrk_pkg.sv]
// shared types, constants and helpers for the encoder position and velocity tracker
package eptrk_pkg;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_TICK   = 2'd1,
    OP_PRESET = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COUNTS_PER_REV = 2'd0,
    REG_FEEDBACK_COEFF = 2'd1,
    REG_GAIN_COEFF     = 2'd2
  } cfg_reg_t;

  localparam int unsigned PPR_W   = 17;
  localparam int unsigned COEFF_W = 32;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 2;

  localparam logic [PPR_W-1:0] PPR_MIN   = 17'd4;
  localparam logic [PPR_W-1:0] PPR_MAX   = 17'd65536;
  localparam logic [PPR_W-1:0] PPR_RESET = 17'd2400;

  localparam logic signed [COEFF_W-1:0] FB_RESET   = 32'sd971480698;
  localparam logic [COEFF_W-1:0]        GAIN_RESET = 32'd16340;

  localparam logic signed [COEFF_W-1:0] OMEGA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEFF_W-1:0] OMEGA_MIN = 32'sh8000_0000;

  // half-up rounding term for the Q2.30 feedback product
  localparam logic signed [63:0] FB_ROUND = 64'sd536870912;
  localparam int unsigned        FB_FRAC  = 30;

  // floor(x / 360) as x * ceil(2^26 / 360) >> 26, exact for any 17 bit x
  localparam int unsigned        DIV360_SHIFT = 26;
  localparam logic [17:0]        DIV360_K     = 18'd186414;
  localparam logic [PPR_W-1:0]   DEG_PER_REV  = 17'd360;

  // ppr split as ppr = 360 * quot + rem, reset value of 2400 counts
  localparam logic [7:0] PQ_RESET = 8'd6;
  localparam logic [8:0] PR_RESET = 9'd240;

  typedef struct packed {
    logic [PPR_W-1:0]          ppr;   // clamped counts per revolution
    logic [7:0]                pq;    // ppr / 360
    logic [8:0]                pr;    // ppr % 360
    logic signed [COEFF_W-1:0] fb;    // filter pole, Q2.30
    logic [COEFF_W-1:0]        gain;  // gain, Q16.16
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DIR_W-1:0] dir;
    logic             neg;   // preset angle is negative
    logic [16:0]      lo;    // |angle| * (ppr % 360)
    logic [15:0]      hi;    // |angle| * (ppr / 360)
  } item_t;

  function automatic logic [8:0] div360(input logic [PPR_W-1:0] x);
    logic [34:0] prod;
    prod = 35'(x) * 35'(DIV360_K);
    return prod[34:DIV360_SHIFT];
  endfunction

endpackage

[rtl/core/encoder_position_velocity_tracker_top.sv]
// top level of the encoder position and filtered velocity tracker
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | sink      | in_tvalid/in_tready | tuser opcode, tdata direction, start angle
//  out_    | source    | out_tvalid/tready   | tdata position count, omega q16.16
//  cfg_    | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// every item yields exactly one result item, through the input register and then the result register
// one item per cycle sustained while out_tready stays high: input register, one update pass, result register
// the state update (the omega feedback multiply and add) is combinational between the state registers
// synchronous active-low reset clears position, previous sample and velocity
// a stalled result holds the update stage, which then holds the input register
module encoder_position_velocity_tracker_top
  import eptrk_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 17
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input item channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [15:0]                          in_tdata,  // [1:0] direction, [10:2] start_angle
  input  logic [OP_W-1:0]                      in_tuser,  // [1:0] opcode
  // result item channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((COUNT_WIDTH+COEFF_W+7)/8)*8-1:0] out_tdata,  // position_count, then omega_q16
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [IDX_W-1:0]                     cfg_index,
  input  logic [COEFF_W-1:0]                   cfg_data
);

  localparam int unsigned OUT_W = ((COUNT_WIDTH + COEFF_W + 7) / 8) * 8;

  cfg_t                      cfg;
  item_t                     itm;
  logic                      s1_vld;
  logic                      fire;
  logic                      in_take;
  logic [COUNT_WIDTH-1:0]    pos_nxt;
  logic signed [COEFF_W-1:0] omega_nxt;

  // register writes are never held off
  assign cfg_ready = 1'b1;

  // update pass runs when the result register is empty or being emptied
  assign fire      = s1_vld && (!out_tvalid || out_tready);
  assign in_tready = !s1_vld || fire;
  assign in_take   = in_tvalid && in_tready;

  eptrk_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  eptrk_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_take),
    .drain (fire),
    .op    (in_tuser),
    .dir   (in_tdata[DIR_W-1:0]),
    .angle (in_tdata[DIR_W+ANGLE_W-1:DIR_W]),
    .cfg   (cfg),
    .vld   (s1_vld),
    .itm   (itm)
  );

  eptrk_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .itm       (itm),
    .cfg       (cfg),
    .pos_nxt   (pos_nxt),
    .omega_nxt (omega_nxt)
  );

  eptrk_out_stage #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .OUT_W       (OUT_W)
  ) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (fire),
    .pos   (pos_nxt),
    .omega (omega_nxt),
    .ready (out_tready),
    .vld   (out_tvalid),
    .data  (out_tdata)
  );

endmodule

[rtl/core/eptrk_cfg.sv]
// configuration registers with clamped ppr and its precomputed split by 360
module eptrk_cfg
  import eptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [COEFF_W-1:0]  wr_data,
  output cfg_t                cfg
);

  logic [PPR_W-1:0]          ppr_r, ppr_nxt;
  logic [7:0]                pq_r, pq_nxt;
  logic [8:0]                pr_r, pr_nxt;
  logic signed [COEFF_W-1:0] fb_r;
  logic [COEFF_W-1:0]        gain_r;
  logic [PPR_W-1:0]          raw;
  logic [PPR_W-1:0]          pq_full;
  logic [8:0]                pq_div;

  // clamp and split on the write itself so the split is ready with ppr
  always_comb begin
    raw = wr_data[PPR_W-1:0];
    if (raw < PPR_MIN) begin
      ppr_nxt = PPR_MIN;
    end else if (raw > PPR_MAX) begin
      ppr_nxt = PPR_MAX;
    end else begin
      ppr_nxt = raw;
    end
    pq_div  = div360(ppr_nxt);
    pq_nxt  = pq_div[7:0];
    pq_full = {9'd0, pq_nxt};
    pr_nxt  = 9'(ppr_nxt - pq_full * DEG_PER_REV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r  <= PPR_RESET;
      pq_r   <= PQ_RESET;
      pr_r   <= PR_RESET;
      fb_r   <= FB_RESET;
      gain_r <= GAIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_COUNTS_PER_REV: begin
          ppr_r <= ppr_nxt;
          pq_r  <= pq_nxt;
          pr_r  <= pr_nxt;
        end
        REG_FEEDBACK_COEFF: fb_r <= wr_data;
        REG_GAIN_COEFF:     gain_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{ppr: ppr_r, pq: pq_r, pr: pr_r, fb: fb_r, gain: gain_r};

endmodule

[rtl/core/eptrk_in_stage.sv]
// input register with the preset angle scaled against the ppr split
module eptrk_in_stage
  import eptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                drain,
  input  logic [OP_W-1:0]     op,
  input  logic [DIR_W-1:0]    dir,
  input  logic [ANGLE_W-1:0]  angle,
  input  cfg_t                cfg,
  output logic                vld,
  output item_t               itm
);

  logic        vld_r;
  item_t       itm_r, itm_nxt;
  logic [8:0]  mag;
  logic [17:0] lo_full;
  logic [16:0] hi_full;

  always_comb begin
    mag     = angle[ANGLE_W-1] ? 9'(-angle) : angle;
    lo_full = 18'(mag) * 18'(cfg.pr);
    hi_full = 17'(mag) * 17'(cfg.pq);
    itm_nxt = '{op: op, dir: dir, neg: angle[ANGLE_W-1],
                lo: lo_full[16:0], hi: hi_full[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (drain) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      itm_r <= itm_nxt;
    end
  end

  assign vld = vld_r;
  assign itm = itm_r;

endmodule

[rtl/core/eptrk_core.sv]
// position, previous sample and velocity state with the per-item update
module eptrk_core
  import eptrk_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  item_t                         itm,
  input  cfg_t                          cfg,
  output logic [COUNT_WIDTH-1:0]        pos_nxt,
  output logic signed [COEFF_W-1:0]     omega_nxt
);

  localparam int unsigned EW = ((COUNT_WIDTH > PPR_W) ? COUNT_WIDTH : PPR_W) + 3;
  localparam int unsigned PW = EW + COEFF_W + 1;
  localparam int unsigned AW = PW + 1;

  logic [COUNT_WIDTH-1:0]        pos_r, prev_r;
  logic [COUNT_WIDTH-1:0]        prev_nxt;
  logic signed [COEFF_W-1:0]     omega_r;

  logic signed [EW-1:0] pos_e, prev_e, ppr_e, half_e, dir_e;
  logic signed [EW-1:0] step_sum, step_w;
  logic signed [EW-1:0] d0, ad, u, d, q_e, preset_w;
  logic                 opposite;
  logic [8:0]           lo_q;
  logic signed [63:0]   fb_prod;
  logic signed [63:0]   fb_rnd;
  logic signed [AW-1:0] fb_term;
  logic signed [PW-1:0] g_prod;
  logic signed [AW-1:0] acc;
  logic signed [COEFF_W-1:0] omega_tick;

  always_comb begin
    pos_e  = EW'($signed(pos_r));
    prev_e = EW'($signed(prev_r));
    ppr_e  = $signed(EW'(cfg.ppr));
    half_e = $signed(EW'(cfg.ppr >> 1));
    dir_e  = EW'($signed(itm.dir));

    // step with a single wrap into (-ppr/2, ppr/2]
    step_sum = pos_e + dir_e;
    if (step_sum > half_e) begin
      step_w = step_sum - ppr_e;
    end else if (step_sum <= -half_e) begin
      step_w = step_sum + ppr_e;
    end else begin
      step_w = step_sum;
    end

    // unwrap previous sample across the half-turn seam
    d0       = pos_e - prev_e;
    ad       = (d0 < 0) ? -d0 : d0;
    opposite = (pos_e > 0 && prev_e < 0) || (pos_e < 0 && prev_e > 0);
    u        = prev_e;
    if (opposite && ((ad <<< 2) > ppr_e)) begin
      u = (prev_e > 0) ? prev_e - ppr_e : prev_e + ppr_e;
    end
    d = pos_e - u;

    // omega = round(a * omega_r / 2^30) + g * d, saturated
    fb_prod = 64'(cfg.fb) * 64'(omega_r);
    fb_rnd  = fb_prod + FB_ROUND;
    fb_term = AW'(fb_rnd >>> FB_FRAC);
    g_prod  = PW'($signed({1'b0, cfg.gain})) * PW'(d);
    acc     = fb_term + AW'(g_prod);
    if (acc > AW'(OMEGA_MAX)) begin
      omega_tick = OMEGA_MAX;
    end else if (acc < AW'(OMEGA_MIN)) begin
      omega_tick = OMEGA_MIN;
    end else begin
      omega_tick = acc[COEFF_W-1:0];
    end

    // preset: trunc(angle * ppr / 360) from the split products
    lo_q     = div360(itm.lo);
    q_e      = $signed(EW'(itm.hi) + EW'(lo_q));
    preset_w = itm.neg ? -q_e : q_e;

    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    omega_nxt = omega_r;
    case (itm.op)
      OP_STEP: pos_nxt = step_w[COUNT_WIDTH-1:0];
      OP_TICK: begin
        omega_nxt = omega_tick;
        prev_nxt  = pos_r;
      end
      OP_PRESET: begin
        pos_nxt  = preset_w[COUNT_WIDTH-1:0];
        prev_nxt = preset_w[COUNT_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      prev_r  <= '0;
      omega_r <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      omega_r <= omega_nxt;
    end
  end

endmodule

[rtl/core/eptrk_out_stage.sv]
// result register holding one item until the consumer takes it
module eptrk_out_stage
  import eptrk_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 17,
  parameter int unsigned OUT_W       = 56
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [COUNT_WIDTH-1:0]    pos,
  input  logic signed [COEFF_W-1:0] omega,
  input  logic                      ready,
  output logic                      vld,
  output logic [OUT_W-1:0]          data
);

  logic             vld_r;
  logic [OUT_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= OUT_W'({omega, pos});
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

[rtl/core/eptrk_checker.sv]
// port-level checks for the tracker, bound to the top level
module eptrk_checker #(
  parameter int unsigned OUT_W = 56
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a result waiting for the consumer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // its payload does not change under a stall
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  // a result rises from idle only once an accepted item has passed the input register and the result register
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result item without an accepted input item");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the result side empty the input side must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!out_tvalid) && $past(rst_n) |-> in_tready)
    else $error("input blocked with nothing pending");

endmodule

bind encoder_position_velocity_tracker_top eptrk_checker #(
  .OUT_W (((COUNT_WIDTH + 32 + 7) / 8) * 8)
) u_eptrk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
